// ===== sv/sscd_pkg.sv =====
// Package for the segment closest-approach unit: field widths, derived datapath
// widths, result codes and the packed payload types of both channels.
// No dependencies.
package sscd_pkg;

  // Fixed field formats
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // Datapath widths: coordinate difference, dot product, cross term
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int DOT_W  = 2 * DIFF_W + 2;
  localparam int NUM_W  = 2 * DOT_W + 1;

  // Operand slice of one partial product in the pipelined multipliers
  localparam int MUL_CHUNK = 34;

  // Stage counts of the two multiplier banks
  localparam int MUL1_STAGES = ((DIFF_W + MUL_CHUNK - 1) / MUL_CHUNK) *
                               ((DIFF_W + MUL_CHUNK - 1) / MUL_CHUNK);
  localparam int MUL2_STAGES = ((DOT_W + MUL_CHUNK - 1) / MUL_CHUNK) *
                               ((DOT_W + MUL_CHUNK - 1) / MUL_CHUNK);

  // Result codes
  typedef enum logic [1:0] {
    OC_HIT      = 2'd0,
    OC_PARALLEL = 2'd1,
    OC_RANGE    = 2'd2
  } outcome_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_start_x;
    logic signed [COORD_WIDTH-1:0] a_start_y;
    logic signed [COORD_WIDTH-1:0] a_start_z;
    logic signed [COORD_WIDTH-1:0] a_end_x;
    logic signed [COORD_WIDTH-1:0] a_end_y;
    logic signed [COORD_WIDTH-1:0] a_end_z;
    logic signed [COORD_WIDTH-1:0] b_start_x;
    logic signed [COORD_WIDTH-1:0] b_start_y;
    logic signed [COORD_WIDTH-1:0] b_start_z;
    logic signed [COORD_WIDTH-1:0] b_end_x;
    logic signed [COORD_WIDTH-1:0] b_end_y;
    logic signed [COORD_WIDTH-1:0] b_end_z;
  } seg_t;

  typedef struct packed {
    logic                          hit;
    logic [1:0]                    outcome;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic [FRAC_BITS:0]            param_a;
  } res_t;

endpackage

// ===== sv/sscd_mul.sv =====
// Pipelined signed multiplier: one slice-by-slice partial product per stage,
// accumulated down the pipe. Stage loads follow the caller's enable vector.
// No package dependencies.
module sscd_mul #(
  parameter int WA = 34,
  parameter int WB = 34,
  parameter int CH = 34,
  parameter int NS = 1
) (
  input  logic                    clk,
  input  logic [NS-1:0]           en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NA = (WA + CH - 1) / CH;
  localparam int NB = (WB + CH - 1) / CH;
  localparam int XA = NA * CH;
  localparam int XB = NB * CH;
  localparam int WP = WA + WB;
  localparam int PW = 2 * CH + 2;

  logic signed [XA-1:0] a_r   [NS];
  logic signed [XB-1:0] b_r   [NS];
  logic signed [WP-1:0] acc_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int I  = s / NB;
    localparam int J  = s % NB;
    localparam int SH = (I + J) * CH;

    logic signed [XA-1:0] a_src;
    logic signed [XB-1:0] b_src;
    logic signed [WP-1:0] acc_prev;
    logic [CH-1:0]        a_ch;
    logic [CH-1:0]        b_ch;
    logic signed [CH:0]   a_op;
    logic signed [CH:0]   b_op;
    logic signed [PW-1:0] pp;
    logic signed [WP-1:0] ppx;
    logic signed [WP-1:0] acc_next;

    // Take operands from the ports at the first stage, else from the stage before
    if (s == 0) begin : g_first
      assign a_src    = XA'(a);
      assign b_src    = XB'(b);
      assign acc_prev = '0;
    end else begin : g_rest
      assign a_src    = a_r[s-1];
      assign b_src    = b_r[s-1];
      assign acc_prev = acc_r[s-1];
    end

    // Low slices are unsigned, the top slice carries the sign
    assign a_ch = a_src[I*CH +: CH];
    assign b_ch = b_src[J*CH +: CH];
    assign a_op = (I == NA - 1) ? signed'({a_ch[CH-1], a_ch}) : signed'({1'b0, a_ch});
    assign b_op = (J == NB - 1) ? signed'({b_ch[CH-1], b_ch}) : signed'({1'b0, b_ch});
    assign pp   = a_op * b_op;
    assign ppx  = WP'(pp);
    assign acc_next = acc_prev + (ppx <<< SH);

    // Advance operands and partial sum
    always_ff @(posedge clk) begin
      if (en[s]) begin
        a_r[s]   <= a_src;
        b_r[s]   <= b_src;
        acc_r[s] <= acc_next;
      end
    end
  end

  assign p = acc_r[NS-1];

endmodule

// ===== sv/sscd_div.sv =====
// Pipelined restoring divider: one quotient bit per stage for the low QB bits,
// the top quotient bit and first remainder come in from the caller.
// No package dependencies.
module sscd_div #(
  parameter int WN = 137,
  parameter int QB = 16
) (
  input  logic          clk,
  input  logic [QB-1:0] en,
  input  logic [WN-1:0] rem,
  input  logic [WN-1:0] den,
  input  logic [QB:0]   q_in,
  output logic [QB:0]   q
);

  logic [WN-1:0] rem_r [QB];
  logic [WN-1:0] den_r [QB];
  logic [QB:0]   q_r   [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [WN-1:0] rem_src;
    logic [WN-1:0] den_src;
    logic [QB:0]   q_src;
    logic [WN:0]   rem2;
    logic [WN:0]   diff;
    logic          ge;
    logic [WN-1:0] rem_next;
    logic [QB:0]   q_next;

    if (s == 0) begin : g_first
      assign rem_src = rem;
      assign den_src = den;
      assign q_src   = q_in;
    end else begin : g_rest
      assign rem_src = rem_r[s-1];
      assign den_src = den_r[s-1];
      assign q_src   = q_r[s-1];
    end

    // Shift in a zero, subtract the divisor when it fits
    assign rem2     = {rem_src, 1'b0};
    assign diff     = rem2 - {1'b0, den_src};
    assign ge       = rem2 >= {1'b0, den_src};
    assign rem_next = ge ? diff[WN-1:0] : rem2[WN-1:0];

    always_comb begin
      q_next             = q_src;
      q_next[QB-1-s]     = ge;
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s] <= rem_next;
        den_r[s] <= den_src;
        q_r[s]   <= q_next;
      end
    end
  end

  assign q = q_r[QB-1];

endmodule

// ===== sv/segment_segment_closest_hit_unit.sv =====
// Top level of the segment closest-approach unit: pipeline control, dot
// products, cross terms, classification, division and point reconstruction.
// Depends on sscd_pkg, sscd_mul and sscd_div.
//
//   channel  direction  payload         transfer when
//   seg      in         sscd_pkg::seg_t seg_valid && seg_ready
//   res      out        sscd_pkg::res_t res_valid && res_ready
//
// One segment pair enters per cycle while seg_ready is high; each result passes
// through the difference stage, 1 dot-product multiplier stage, dot-product sum,
// 4 cross-term multiplier stages, subtract, sign, class, 16 divider stages,
// scale and output.
// Every stage has a valid bit and loads when it is empty or the stage after it
// moves, so a stall at res holds all data and bubbles still fill up.
// Synchronous reset clears only the valid bits.
module segment_segment_closest_hit_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           seg_valid,
  output logic           seg_ready,
  input  sscd_pkg::seg_t seg,
  output logic           res_valid,
  input  logic           res_ready,
  output sscd_pkg::res_t res
);

  localparam int CW  = sscd_pkg::COORD_WIDTH;
  localparam int FB  = sscd_pkg::FRAC_BITS;
  localparam int D   = sscd_pkg::DIFF_W;
  localparam int DW  = sscd_pkg::DOT_W;
  localparam int NW  = sscd_pkg::NUM_W;
  localparam int CH  = sscd_pkg::MUL_CHUNK;
  localparam int N1  = sscd_pkg::MUL1_STAGES;
  localparam int N2  = sscd_pkg::MUL2_STAGES;
  localparam int PQ  = FB + 2 + D;

  // Stage indexes
  localparam int K_DOT  = N1 + 1;
  localparam int K_SUB  = K_DOT + N2 + 1;
  localparam int K_NORM = K_SUB + 1;
  localparam int K_CLS  = K_SUB + 2;
  localparam int K_DIV0 = K_CLS + 1;
  localparam int K_MUL  = K_CLS + FB + 1;
  localparam int K_OUT  = K_MUL + 1;
  localparam int NST    = K_OUT + 1;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  logic [NST-1:0] v;
  logic [NST:0]   en;

  // ---------------------------------------------------------------- control
  // A stage may load when it is empty or its successor moves on
  always_comb begin
    en[NST] = res_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign seg_ready = en[0];
  assign res_valid = v[K_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= seg_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------- stage 0: diffs
  logic signed [CW-1:0] as_in [3];
  logic signed [CW-1:0] ae_in [3];
  logic signed [CW-1:0] bs_in [3];
  logic signed [CW-1:0] be_in [3];

  assign as_in[0] = seg.a_start_x;
  assign as_in[1] = seg.a_start_y;
  assign as_in[2] = seg.a_start_z;
  assign ae_in[0] = seg.a_end_x;
  assign ae_in[1] = seg.a_end_y;
  assign ae_in[2] = seg.a_end_z;
  assign bs_in[0] = seg.b_start_x;
  assign bs_in[1] = seg.b_start_y;
  assign bs_in[2] = seg.b_start_z;
  assign be_in[0] = seg.b_end_x;
  assign be_in[1] = seg.b_end_y;
  assign be_in[2] = seg.b_end_z;

  logic signed [CW-1:0]  a1_r [K_MUL+1][3];
  logic signed [D-1:0]   ad_r [K_MUL+1][3];
  logic [1:0]            oc_r [K_MUL+1];
  logic signed [D-1:0]   bd_r [3];
  logic signed [D-1:0]   wd_r [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < 3; c++) begin
        a1_r[0][c] <= as_in[c];
        ad_r[0][c] <= D'(ae_in[c]) - D'(as_in[c]);
        bd_r[c]    <= D'(be_in[c]) - D'(bs_in[c]);
        wd_r[c]    <= D'(as_in[c]) - D'(bs_in[c]);
      end
      oc_r[0] <= sscd_pkg::OC_HIT;
    end
  end

  // Carry the start point, A and the outcome code down the pipe
  for (genvar k = 1; k <= K_MUL; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) begin
        a1_r[k] <= a1_r[k-1];
        ad_r[k] <= ad_r[k-1];
        if (k != K_CLS) begin
          oc_r[k] <= oc_r[k-1];
        end
      end
    end
  end

  // ------------------------------------------------- dot product term bank
  logic signed [2*D-1:0] p_aa [3];
  logic signed [2*D-1:0] p_bb [3];
  logic signed [2*D-1:0] p_ab [3];
  logic signed [2*D-1:0] p_wa [3];
  logic signed [2*D-1:0] p_wb [3];

  for (genvar c = 0; c < 3; c++) begin : g_term
    sscd_mul #(.WA(D), .WB(D), .CH(CH), .NS(N1)) u_aa (
      .clk(clk), .en(en[1 +: N1]), .a(ad_r[0][c]), .b(ad_r[0][c]), .p(p_aa[c]));
    sscd_mul #(.WA(D), .WB(D), .CH(CH), .NS(N1)) u_bb (
      .clk(clk), .en(en[1 +: N1]), .a(bd_r[c]), .b(bd_r[c]), .p(p_bb[c]));
    sscd_mul #(.WA(D), .WB(D), .CH(CH), .NS(N1)) u_ab (
      .clk(clk), .en(en[1 +: N1]), .a(ad_r[0][c]), .b(bd_r[c]), .p(p_ab[c]));
    sscd_mul #(.WA(D), .WB(D), .CH(CH), .NS(N1)) u_wa (
      .clk(clk), .en(en[1 +: N1]), .a(wd_r[c]), .b(ad_r[0][c]), .p(p_wa[c]));
    sscd_mul #(.WA(D), .WB(D), .CH(CH), .NS(N1)) u_wb (
      .clk(clk), .en(en[1 +: N1]), .a(wd_r[c]), .b(bd_r[c]), .p(p_wb[c]));
  end

  // Sum the three terms of each dot product
  logic signed [DW-1:0] aa_r, bb_r, ab_r, wa_r, wb_r;

  always_ff @(posedge clk) begin
    if (en[K_DOT]) begin
      aa_r <= DW'(p_aa[0]) + DW'(p_aa[1]) + DW'(p_aa[2]);
      bb_r <= DW'(p_bb[0]) + DW'(p_bb[1]) + DW'(p_bb[2]);
      ab_r <= DW'(p_ab[0]) + DW'(p_ab[1]) + DW'(p_ab[2]);
      wa_r <= DW'(p_wa[0]) + DW'(p_wa[1]) + DW'(p_wa[2]);
      wb_r <= DW'(p_wb[0]) + DW'(p_wb[1]) + DW'(p_wb[2]);
    end
  end

  // ------------------------------------------------------ cross term bank
  logic signed [2*DW-1:0] x_aabb, x_abab, x_wbab, x_wabb, x_wbaa, x_waab;

  sscd_mul #(.WA(DW), .WB(DW), .CH(CH), .NS(N2)) u_aabb (
    .clk(clk), .en(en[K_DOT+1 +: N2]), .a(aa_r), .b(bb_r), .p(x_aabb));
  sscd_mul #(.WA(DW), .WB(DW), .CH(CH), .NS(N2)) u_abab (
    .clk(clk), .en(en[K_DOT+1 +: N2]), .a(ab_r), .b(ab_r), .p(x_abab));
  sscd_mul #(.WA(DW), .WB(DW), .CH(CH), .NS(N2)) u_wbab (
    .clk(clk), .en(en[K_DOT+1 +: N2]), .a(wb_r), .b(ab_r), .p(x_wbab));
  sscd_mul #(.WA(DW), .WB(DW), .CH(CH), .NS(N2)) u_wabb (
    .clk(clk), .en(en[K_DOT+1 +: N2]), .a(wa_r), .b(bb_r), .p(x_wabb));
  sscd_mul #(.WA(DW), .WB(DW), .CH(CH), .NS(N2)) u_wbaa (
    .clk(clk), .en(en[K_DOT+1 +: N2]), .a(wb_r), .b(aa_r), .p(x_wbaa));
  sscd_mul #(.WA(DW), .WB(DW), .CH(CH), .NS(N2)) u_waab (
    .clk(clk), .en(en[K_DOT+1 +: N2]), .a(wa_r), .b(ab_r), .p(x_waab));

  // Denominator and both numerators
  logic signed [NW-1:0] den_r, n1_r, n2_r;

  always_ff @(posedge clk) begin
    if (en[K_SUB]) begin
      den_r <= NW'(x_aabb) - NW'(x_abab);
      n1_r  <= NW'(x_wbab) - NW'(x_wabb);
      n2_r  <= NW'(x_wbaa) - NW'(x_waab);
    end
  end

  // Make the denominator positive, flag a zero one
  logic signed [NW-1:0] dp_r, n1p_r, n2p_r;
  logic                 dz_r;

  always_ff @(posedge clk) begin
    if (en[K_NORM]) begin
      dz_r <= (den_r == '0);
      if (den_r[NW-1]) begin
        dp_r  <= -den_r;
        n1p_r <= -n1_r;
        n2p_r <= -n2_r;
      end else begin
        dp_r  <= den_r;
        n1p_r <= n1_r;
        n2p_r <= n2_r;
      end
    end
  end

  // ---------------------------------- classify and take the top quotient bit
  logic          out_rng;
  logic          q_top;
  logic [NW-1:0] rem0_r;
  logic [NW-1:0] dv_r;
  logic [FB:0]   q0_r;

  assign out_rng = n1p_r[NW-1] || (n1p_r > dp_r) || n2p_r[NW-1] || (n2p_r > dp_r);
  assign q_top   = (n1p_r >= dp_r);

  always_ff @(posedge clk) begin
    if (en[K_CLS]) begin
      if (dz_r) begin
        oc_r[K_CLS] <= sscd_pkg::OC_PARALLEL;
      end else if (out_rng) begin
        oc_r[K_CLS] <= sscd_pkg::OC_RANGE;
      end else begin
        oc_r[K_CLS] <= sscd_pkg::OC_HIT;
      end
      rem0_r <= q_top ? NW'(n1p_r - dp_r) : NW'(n1p_r);
      dv_r   <= NW'(dp_r);
      q0_r   <= {q_top, {FB{1'b0}}};
    end
  end

  // ------------------------------------------------------------- divider
  logic [FB:0] q_div;

  sscd_div #(.WN(NW), .QB(FB)) u_div (
    .clk (clk),
    .en  (en[K_DIV0 +: FB]),
    .rem (rem0_r),
    .den (dv_r),
    .q_in(q0_r),
    .q   (q_div)
  );

  // ------------------------------------------------- scale A by the parameter
  logic signed [FB+1:0] q_s;
  logic signed [PQ-1:0] pq_r [3];
  logic [FB:0]          q_r;

  assign q_s = signed'({1'b0, q_div});

  always_ff @(posedge clk) begin
    if (en[K_MUL]) begin
      q_r <= q_div;
      for (int c = 0; c < 3; c++) begin
        pq_r[c] <= PQ'(q_s) * PQ'(ad_r[K_MUL-1][c]);
      end
    end
  end

  // ------------------------------------ add start point, saturate, output
  logic signed [PQ-1:0] sh   [3];
  logic signed [PQ:0]   sum  [3];
  logic signed [CW-1:0] sat  [3];
  logic                 is_hit;

  assign is_hit = (oc_r[K_MUL] == sscd_pkg::OC_HIT);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sh[c]  = pq_r[c] >>> FB;
      sum[c] = (PQ+1)'(a1_r[K_MUL][c]) + (PQ+1)'(sh[c]);
      if (sum[c] > (PQ+1)'(CMAX)) begin
        sat[c] = CMAX;
      end else if (sum[c] < (PQ+1)'(CMIN)) begin
        sat[c] = CMIN;
      end else begin
        sat[c] = sum[c][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[K_OUT]) begin
      res.hit     <= is_hit;
      res.outcome <= oc_r[K_MUL];
      res.point_x <= is_hit ? sat[0] : '0;
      res.point_y <= is_hit ? sat[1] : '0;
      res.point_z <= is_hit ? sat[2] : '0;
      res.param_a <= is_hit ? q_r : '0;
    end
  end

endmodule
